/* rtl/lspf_pkg.sv */
// ----------------------------------------------------------------------------
// lspf_pkg: shared types and constants for the shadow point filter
// State codes, register indexes, sequencer steps and CORDIC constants.
// ----------------------------------------------------------------------------
package lspf_pkg;

    localparam int MAX_POINTS_DEF   = 4096;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS     = 20;
    localparam int CW               = 33;   // CORDIC x/y width, signed
    localparam int ZW               = 25;   // CORDIC angle width, signed
    localparam int ACC_W            = 160;  // accumulator of the MAC unit
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [15:0] RANGE_MIN_RST = 16'd0;
    localparam logic [15:0] RANGE_MAX_RST = 16'd65535;
    localparam logic [15:0] ANGLE_START_RST = 16'd0;
    localparam logic [15:0] ANGLE_STEP_RST = 16'd64;
    localparam logic [15:0] COS_THR_RST = 16'd62259;

    typedef enum logic [2:0] {
        REG_RANGE_MIN   = 3'd0,
        REG_RANGE_MAX   = 3'd1,
        REG_ANGLE_START = 3'd2,
        REG_ANGLE_STEP  = 3'd3,
        REG_COS_THR     = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_PREP,
        ST_ROTATE,
        ST_PROJ_X,
        ST_PROJ_Y,
        ST_PAIR,
        ST_TEST,
        ST_FINISH
    } state_t;

    // MAC steps of the shadow test
    typedef enum logic [4:0] {
        OP_THR2,
        OP_NAB0, OP_NAB1,
        OP_NM0, OP_NM1,
        OP_DOT0, OP_DOT1,
        OP_DABS,
        OP_DSQ0, OP_DSQ1, OP_DSQ2, OP_DSQ3,
        OP_R1_0, OP_R1_1,
        OP_R2_0, OP_R2_1, OP_R2_2, OP_R2_3, OP_R2_4, OP_R2_5,
        OP_CMP
    } op_t;

    // atan(2^-i) in units of 2^-24 of a circle
    function automatic logic [21:0] atan_lut(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2097152;
            5'd1:    v = 22'd1238021;
            5'd2:    v = 22'd654136;
            5'd3:    v = 22'd332050;
            5'd4:    v = 22'd166669;
            5'd5:    v = 22'd83416;
            5'd6:    v = 22'd41718;
            5'd7:    v = 22'd20860;
            5'd8:    v = 22'd10430;
            5'd9:    v = 22'd5215;
            5'd10:   v = 22'd2608;
            5'd11:   v = 22'd1304;
            5'd12:   v = 22'd652;
            5'd13:   v = 22'd326;
            5'd14:   v = 22'd163;
            5'd15:   v = 22'd81;
            5'd16:   v = 22'd41;
            5'd17:   v = 22'd20;
            5'd18:   v = 22'd10;
            5'd19:   v = 22'd5;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/lidar_shadow_point_filter.sv */
// ----------------------------------------------------------------------------
// lidar_shadow_point_filter: laser scan shadow (veiling) point removal
// Marks pairs of neighbouring points seen at a grazing angle as removed.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream in scan order; s_tlast marks the last
//   sample of a scan. Results leave on the m_ stream one sample behind: the
//   first sample of a scan gives no result, the last gives two (the held
//   sample, then itself with m_tlast set). The user writes registers over
//   the cfg_ channel (always ready) only while no item is in flight; the
//   block itself does not enforce this. An item that is not usable goes
//   straight to the finish step; a usable item runs the index multiply,
//   CORDIC set-up, 20 CORDIC rotations, two projections and, when paired
//   with a usable neighbour, the pair set-up plus, unless a pair vector is
//   zero, 21 steps of the shadow test on the shared 32x32 MAC; the finish
//   step posts its results once the output register is empty. One item is
//   in work at a time (s_tready is high only when the sequencer is idle).
//   Results sit in a two-entry output register. A finished item is posted
//   only into an empty register, so a stalled receiver holds it back until
//   both entries have drained.
//   Reset clears the sequencer, the scan index, the held sample and loads
//   the register reset values.
// ----------------------------------------------------------------------------
module lidar_shadow_point_filter
    import lspf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] range_mm, [31:16] intensity
    input  logic        s_tuser,    // [0] range_finite
    input  logic        s_tlast,    // last
    // filtered samples
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] range_out_mm, [31:16] intensity_out
    output logic        m_tuser,    // [0] range_out_finite
    output logic        m_tlast,    // last_out
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [23:0] ANG_MASK = ~((24'd1 << (24 - ANGLE_BITS)) - 24'd1);
    localparam logic [IDX_W:0] IDX_WRAP = (IDX_W+1)'(MAX_POINTS);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    op_t    op_reg;
    logic [4:0] iter_reg;

    logic [15:0] range_min_reg, range_max_reg, angle_start_reg, angle_step_reg;
    logic [15:0] cos_thr_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             have_held_reg;

    // current item
    logic [15:0] in_range_reg, in_int_reg;
    logic        in_fin_reg, in_last_reg, cur_usable_reg;
    logic signed [31:0] cur_x_reg, cur_y_reg;
    logic        rm_reg;

    // held item
    logic [15:0] held_range_reg, held_int_reg;
    logic        held_fin_reg, held_usable_reg, held_removed_reg;
    logic signed [31:0] held_x_reg, held_y_reg;

    // CORDIC
    logic [15:0] ang_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic                 cneg_reg;

    // shadow test operands and partial results
    logic [31:0]  abx_reg, aby_reg, mx_reg, my_reg;
    logic         sabx_reg, saby_reg, smx_reg, smy_reg, pair_zero_reg;
    logic [31:0]  thr2_reg;
    logic [63:0]  nab_reg, nm_reg, dmag_reg;
    logic signed [64:0] d_reg;
    logic [127:0] lhs_reg;
    logic [95:0]  r1_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;

    // output register, two entries
    logic        out_valid_reg, pend_valid_reg;
    logic [31:0] out_data_reg, pend_data_reg;
    logic        out_fin_reg, pend_fin_reg, out_last_reg, pend_last_reg;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic in_accept, usable_in, out_free, cordic_done, pair_needed;
    logic [IDX_W:0] idx_inc;

    assign in_accept = s_tvalid && s_tready;
    assign usable_in = s_tuser && (s_tdata[15:0] >= range_min_reg)
                       && (s_tdata[15:0] <= range_max_reg);
    assign out_free    = !out_valid_reg && !pend_valid_reg;
    assign cordic_done = (iter_reg == 5'(CORDIC_STEPS - 1));
    assign pair_needed = have_held_reg && held_usable_reg && cur_usable_reg;
    assign idx_inc     = {1'b0, idx_reg} + (IDX_W+1)'(1);
    assign cfg_ready   = 1'b1;

    // CORDIC set-up: fold the angle into the right half plane
    logic [23:0] p_raw, p_fold, p_quart;
    logic        p_neg;
    assign p_raw   = {ang_reg, 8'd0} & ANG_MASK;
    assign p_quart = p_raw + 24'h400000;
    assign p_neg   = p_quart[23];
    assign p_fold  = p_neg ? (p_raw + 24'h800000) : p_raw;

    // CORDIC rotation step
    logic signed [CW-1:0] x_sh, y_sh;
    logic signed [ZW-1:0] atan_v;
    assign x_sh   = cx_reg >>> iter_reg;
    assign y_sh   = cy_reg >>> iter_reg;
    assign atan_v = ZW'(atan_lut(iter_reg));

    // cosine/sine magnitude and sign for the projection
    logic signed [CW-1:0] cx_neg, cy_neg;
    logic [31:0] c_mag, s_mag;
    assign cx_neg = -cx_reg;
    assign cy_neg = -cy_reg;
    assign c_mag  = cx_reg[CW-1] ? cx_neg[31:0] : cx_reg[31:0];
    assign s_mag  = cy_reg[CW-1] ? cy_neg[31:0] : cy_reg[31:0];

    // pair vectors
    logic signed [32:0] abx_w, aby_w, mx_w, my_w, abx_n, aby_n, mx_n, my_n;
    assign abx_w = 33'(cur_x_reg) - 33'(held_x_reg);
    assign aby_w = 33'(cur_y_reg) - 33'(held_y_reg);
    assign mx_w  = 33'(cur_x_reg) + 33'(held_x_reg);
    assign my_w  = 33'(cur_y_reg) + 33'(held_y_reg);
    assign abx_n = -abx_w;
    assign aby_n = -aby_w;
    assign mx_n  = -mx_w;
    assign my_n  = -my_w;

    logic signed [64:0] d_neg;
    assign d_neg = -d_reg;

    // ------------------------------------------------------------------
    // shared MAC unit: acc = (clr ? 0 : acc) +/- (a * b) << (32 * sh)
    // ------------------------------------------------------------------
    logic        mac_en, mac_clr, mac_neg;
    logic [31:0] mul_a, mul_b;
    logic [2:0]  mac_sh;
    logic [63:0] prod;
    logic [ACC_W-1:0] addend, addend_s, acc_base;

    assign prod = mul_a * mul_b;

    always_comb
    begin
        case (mac_sh)
            3'd0:    addend = {96'd0, prod};
            3'd1:    addend = {64'd0, prod, 32'd0};
            3'd2:    addend = {32'd0, prod, 64'd0};
            3'd3:    addend = {prod, 96'd0};
            default: addend = '0;
        endcase
    end

    // subtraction as inverted addend plus carry in, one adder
    assign addend_s = mac_neg ? ~addend : addend;
    assign acc_base = mac_clr ? '0 : acc_reg;
    assign acc_next = acc_base + addend_s + ACC_W'(mac_neg);

    // operand selection
    always_comb
    begin
        mac_en  = 1'b0;
        mac_clr = 1'b0;
        mac_neg = 1'b0;
        mac_sh  = 3'd0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            ST_ANGLE:
            begin
                mac_en  = 1'b1;
                mac_clr = 1'b1;
                mul_a   = 32'(idx_reg);
                mul_b   = {16'd0, angle_step_reg};
            end
            ST_PROJ_X:
            begin
                mac_en  = 1'b1;
                mac_clr = 1'b1;
                mul_a   = {16'd0, in_range_reg};
                mul_b   = c_mag;
                mac_neg = cx_reg[CW-1] ^ cneg_reg;
            end
            ST_PROJ_Y:
            begin
                mac_en  = 1'b1;
                mac_clr = 1'b1;
                mul_a   = {16'd0, in_range_reg};
                mul_b   = s_mag;
                mac_neg = cy_reg[CW-1] ^ cneg_reg;
            end
            ST_TEST:
            begin
                mac_en = 1'b1;
                case (op_reg)
                    OP_THR2:
                    begin
                        mac_clr = 1'b1;
                        mul_a = {16'd0, cos_thr_reg};
                        mul_b = {16'd0, cos_thr_reg};
                    end
                    OP_NAB0: begin mac_clr = 1'b1; mul_a = abx_reg; mul_b = abx_reg; end
                    OP_NAB1: begin mul_a = aby_reg; mul_b = aby_reg; end
                    OP_NM0:  begin mac_clr = 1'b1; mul_a = mx_reg; mul_b = mx_reg; end
                    OP_NM1:  begin mul_a = my_reg; mul_b = my_reg; end
                    OP_DOT0:
                    begin
                        mac_clr = 1'b1;
                        mul_a = abx_reg;
                        mul_b = mx_reg;
                        mac_neg = sabx_reg ^ smx_reg;
                    end
                    OP_DOT1:
                    begin
                        mul_a = aby_reg;
                        mul_b = my_reg;
                        mac_neg = saby_reg ^ smy_reg;
                    end
                    OP_DABS: mac_en = 1'b0;
                    OP_DSQ0:
                    begin
                        mac_clr = 1'b1;
                        mul_a = dmag_reg[31:0];
                        mul_b = dmag_reg[31:0];
                    end
                    OP_DSQ1:
                    begin
                        mul_a = dmag_reg[31:0]; mul_b = dmag_reg[63:32]; mac_sh = 3'd1;
                    end
                    OP_DSQ2:
                    begin
                        mul_a = dmag_reg[63:32]; mul_b = dmag_reg[31:0]; mac_sh = 3'd1;
                    end
                    OP_DSQ3:
                    begin
                        mul_a = dmag_reg[63:32]; mul_b = dmag_reg[63:32]; mac_sh = 3'd2;
                    end
                    OP_R1_0:
                    begin
                        mac_clr = 1'b1; mul_a = thr2_reg; mul_b = nab_reg[31:0];
                    end
                    OP_R1_1:
                    begin
                        mul_a = thr2_reg; mul_b = nab_reg[63:32]; mac_sh = 3'd1;
                    end
                    OP_R2_0:
                    begin
                        mac_clr = 1'b1; mul_a = r1_reg[31:0]; mul_b = nm_reg[31:0];
                    end
                    OP_R2_1:
                    begin
                        mul_a = r1_reg[31:0]; mul_b = nm_reg[63:32]; mac_sh = 3'd1;
                    end
                    OP_R2_2:
                    begin
                        mul_a = r1_reg[63:32]; mul_b = nm_reg[31:0]; mac_sh = 3'd1;
                    end
                    OP_R2_3:
                    begin
                        mul_a = r1_reg[63:32]; mul_b = nm_reg[63:32]; mac_sh = 3'd2;
                    end
                    OP_R2_4:
                    begin
                        mul_a = r1_reg[95:64]; mul_b = nm_reg[31:0]; mac_sh = 3'd2;
                    end
                    OP_R2_5:
                    begin
                        mul_a = r1_reg[95:64]; mul_b = nm_reg[63:32]; mac_sh = 3'd3;
                    end
                    OP_CMP:  mac_en = 1'b0;
                    default: mac_en = 1'b0;
                endcase
            end
            default: mac_en = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_accept)
                    state_next = usable_in ? ST_ANGLE : ST_FINISH;
            ST_ANGLE:  state_next = ST_PREP;
            ST_PREP:   state_next = ST_ROTATE;
            ST_ROTATE:
                if (cordic_done)
                    state_next = ST_PROJ_X;
            ST_PROJ_X: state_next = ST_PROJ_Y;
            ST_PROJ_Y: state_next = pair_needed ? ST_PAIR : ST_FINISH;
            ST_PAIR:
            begin
                // a zero vector never removes anything
                if ((abx_w == '0 && aby_w == '0) || (mx_w == '0 && my_w == '0))
                    state_next = ST_FINISH;
                else
                    state_next = ST_TEST;
            end
            ST_TEST:
                if (op_reg == OP_CMP)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    logic finish_go;
    assign finish_go = (state_reg == ST_FINISH) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_THR2;
            iter_reg        <= '0;
            idx_reg         <= '0;
            have_held_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            range_min_reg   <= RANGE_MIN_RST;
            range_max_reg   <= RANGE_MAX_RST;
            angle_start_reg <= ANGLE_START_RST;
            angle_step_reg  <= ANGLE_STEP_RST;
            cos_thr_reg     <= COS_THR_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RANGE_MIN:   range_min_reg   <= cfg_data;
                    REG_RANGE_MAX:   range_max_reg   <= cfg_data;
                    REG_ANGLE_START: angle_start_reg <= cfg_data;
                    REG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                    REG_COS_THR:     cos_thr_reg     <= cfg_data;
                    default:         ;
                endcase
            end

            if (state_reg == ST_PREP)
                iter_reg <= '0;
            else if (state_reg == ST_ROTATE)
                iter_reg <= iter_reg + 5'd1;

            if (state_reg == ST_PAIR)
                op_reg <= OP_THR2;
            else if (state_reg == ST_TEST && op_reg != OP_CMP)
                op_reg <= op_t'(op_reg + 5'd1);

            // output drain
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end

            if (finish_go)
            begin
                out_valid_reg  <= have_held_reg || in_last_reg;
                pend_valid_reg <= have_held_reg && in_last_reg;
                if (in_last_reg)
                begin
                    idx_reg       <= '0;
                    have_held_reg <= 1'b0;
                end
                else
                begin
                    have_held_reg <= 1'b1;
                    idx_reg       <= (idx_inc >= IDX_WRAP) ? '0 : idx_inc[IDX_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    logic held_rm, cur_rm_fin, held_rm_fin;
    assign held_rm     = held_removed_reg || rm_reg;
    assign held_rm_fin = held_fin_reg && !held_rm;
    assign cur_rm_fin  = in_fin_reg && !rm_reg;

    always_ff @(posedge clk)
    begin
        if (mac_en)
            acc_reg <= acc_next;

        case (state_reg)
            ST_IDLE:
                if (in_accept)
                begin
                    in_range_reg   <= s_tdata[15:0];
                    in_int_reg     <= s_tdata[31:16];
                    in_fin_reg     <= s_tuser;
                    in_last_reg    <= s_tlast;
                    cur_usable_reg <= usable_in;
                    rm_reg         <= 1'b0;
                end
            ST_ANGLE:
                ang_reg <= acc_next[15:0] + angle_start_reg;
            ST_PREP:
            begin
                cx_reg   <= CORDIC_GAIN;
                cy_reg   <= '0;
                cz_reg   <= ZW'($signed(p_fold));
                cneg_reg <= p_neg;
            end
            ST_ROTATE:
            begin
                if (!cz_reg[ZW-1])
                begin
                    cx_reg <= cx_reg - y_sh;
                    cy_reg <= cy_reg + x_sh;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + y_sh;
                    cy_reg <= cy_reg - x_sh;
                    cz_reg <= cz_reg + atan_v;
                end
            end
            ST_PROJ_X: cur_x_reg <= acc_next[47:16];
            ST_PROJ_Y: cur_y_reg <= acc_next[47:16];
            ST_PAIR:
            begin
                abx_reg  <= abx_w[32] ? abx_n[31:0] : abx_w[31:0];
                aby_reg  <= aby_w[32] ? aby_n[31:0] : aby_w[31:0];
                mx_reg   <= mx_w[32]  ? mx_n[31:0]  : mx_w[31:0];
                my_reg   <= my_w[32]  ? my_n[31:0]  : my_w[31:0];
                sabx_reg <= abx_w[32];
                saby_reg <= aby_w[32];
                smx_reg  <= mx_w[32];
                smy_reg  <= my_w[32];
                pair_zero_reg <= (abx_w == '0 && aby_w == '0) || (mx_w == '0 && my_w == '0);
            end
            ST_TEST:
            begin
                case (op_reg)
                    OP_THR2: thr2_reg <= acc_next[31:0];
                    OP_NAB1: nab_reg  <= acc_next[63:0];
                    OP_NM1:  nm_reg   <= acc_next[63:0];
                    OP_DOT1: d_reg    <= acc_next[64:0];
                    OP_DABS: dmag_reg <= d_reg[64] ? d_neg[63:0] : d_reg[63:0];
                    OP_DSQ3: lhs_reg  <= acc_next[127:0];
                    OP_R1_1: r1_reg   <= acc_next[95:0];
                    // (AB.M)^2 * 2^32 against thr^2 * |AB|^2 * |M|^2
                    OP_CMP:  rm_reg   <= ({lhs_reg, 32'd0} > acc_reg);
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (finish_go)
        begin
            if (have_held_reg)
            begin
                out_data_reg <= {held_rm ? 16'd0 : held_int_reg,
                                 held_rm_fin ? held_range_reg : 16'd0};
                out_fin_reg  <= held_rm_fin;
                out_last_reg <= 1'b0;
            end
            else
            begin
                out_data_reg <= {rm_reg ? 16'd0 : in_int_reg,
                                 cur_rm_fin ? in_range_reg : 16'd0};
                out_fin_reg  <= cur_rm_fin;
                out_last_reg <= 1'b1;
            end
            pend_data_reg <= {rm_reg ? 16'd0 : in_int_reg,
                              cur_rm_fin ? in_range_reg : 16'd0};
            pend_fin_reg  <= cur_rm_fin;
            pend_last_reg <= 1'b1;

            if (!in_last_reg)
            begin
                held_range_reg   <= in_range_reg;
                held_int_reg     <= in_int_reg;
                held_fin_reg     <= in_fin_reg;
                held_usable_reg  <= cur_usable_reg;
                held_x_reg       <= cur_x_reg;
                held_y_reg       <= cur_y_reg;
                held_removed_reg <= rm_reg;
            end
        end
        else if (out_valid_reg && m_tready && pend_valid_reg)
        begin
            out_data_reg <= pend_data_reg;
            out_fin_reg  <= pend_fin_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fin_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // second output entry is only ever behind a full first entry
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without a head result");

    // shadow test only runs on a pair whose vectors are non-zero
    a_test_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) |-> !pair_zero_reg)
        else $error("shadow test on a zero vector");

    // CORDIC moves on to the X projection once its last step is done
    a_cordic_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROTATE && cordic_done) |=> (state_reg == ST_PROJ_X))
        else $error("CORDIC left early or late");

    // the held sample is dropped only at the end of a scan
    a_held_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(have_held_reg) |-> $past(in_last_reg))
        else $error("held sample dropped mid-scan");

    // results are posted only into an empty output register
    a_post_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && state_next == ST_IDLE) |-> out_free)
        else $error("result posted over a full output register");
`endif

endmodule
